FILE: rtl/stft_frame_analyzer_unit_macros.svh
// assertion macros for the stft frame analyzer
// expects signals named clk and rst_n in the enclosing module
`ifndef STFT_FRAME_ANALYZER_UNIT_MACROS_SVH
`define STFT_FRAME_ANALYZER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define SFA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfa check failed");

// next-cycle implication, checked outside reset
`define SFA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfa check failed");

`endif

FILE: rtl/sfa_pkg.sv
// shared types, constants and elaboration-time functions of the stft frame analyzer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sfa_pkg;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_WIN_RD,
    S_WIN_WR,
    S_BF_RA,
    S_BF_RB,
    S_BF_MUL,
    S_BF_WA,
    S_BF_WB,
    S_BIN_RD,
    S_BIN_WAIT,
    S_BIN_INIT,
    S_BIN_CALC,
    S_BIN_OUT
  } ctl_state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic ring_wr;
    logic win_wr;
    logic bf_hold_a;
    logic bf_mul;
    logic bf_wr_a;
    logic bf_wr_b;
    logic bin_load;
    logic bin_init;
    logic bin_step;
  } dp_cmd_t;

  localparam int        MAG_W       = 22;
  localparam int        PH_W        = 16;
  localparam int        SMP_W       = 16;
  localparam int        WS_W        = 24;
  localparam int        HOP_W       = 7;
  localparam int        CALC_STEPS  = 24;
  localparam int        CORDIC_IT   = 16;
  localparam longint    CORDIC_K    = 652032874;
  localparam logic [MAG_W-1:0] MAG_MAX = '1;
  localparam logic [HOP_W-1:0] HOP_RESET = 7'd16;

  // arctangent of 2^-i in 16-bit turns
  localparam logic [14:0] ATAN_TURNS [CORDIC_IT] = '{
    15'd8192, 15'd4836, 15'd2555, 15'd1297, 15'd651, 15'd326, 15'd163, 15'd81,
    15'd41, 15'd20, 15'd10, 15'd5, 15'd3, 15'd1, 15'd1, 15'd0
  };

  // saturate a butterfly sum to the workspace width
  function automatic logic signed [WS_W-1:0] sat_ws(input logic signed [28:0] v);
    logic signed [28:0] hi;
    logic signed [28:0] lo;
    hi = 29'sd8388607;
    lo = -29'sd8388608;
    if (v > hi) return WS_W'(hi);
    if (v < lo) return WS_W'(lo);
    return WS_W'(v);
  endfunction

  // rotation-mode cordic, cos or sin of a 16-bit turn angle in q1.15
  function automatic logic signed [17:0] cordic_cs(input int ang, input logic want_sin);
    longint z;
    longint x;
    longint y;
    longint xs;
    longint ys;
    longint c;
    longint s;
    logic   neg;
    z   = longint'(ang) & 65535;
    x   = CORDIC_K;
    y   = 0;
    neg = 1'b0;
    if (z >= 32768) z = z - 65536;
    if (z > 16384) begin
      z   = z - 32768;
      neg = 1'b1;
    end else if (z < -16384) begin
      z   = z + 32768;
      neg = 1'b1;
    end
    for (int i = 0; i < CORDIC_IT; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(ATAN_TURNS[i]);
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(ATAN_TURNS[i]);
      end
    end
    c = (x + 16384) >>> 15;
    s = (y + 16384) >>> 15;
    if (neg) begin
      c = -c;
      s = -s;
    end
    return want_sin ? 18'(s) : 18'(c);
  endfunction

  // periodic hann weight from a cosine, unsigned q1.15
  function automatic logic [16:0] hann_from_cos(input logic signed [17:0] c);
    longint cl;
    cl = longint'(c);
    if (cl > 32768) cl = 32768;
    if (cl < -32768) cl = -32768;
    return 17'((32768 - cl) >>> 1);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/sfa_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module sfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/sfa_datapath.sv
// datapath: sample ring, fft workspace, window and butterfly arithmetic, magnitude and phase
// depends on sfa_pkg and sfa_ram
`timescale 1ns / 1ps
`default_nettype none

module sfa_datapath #(
  parameter int NFFT = 64
) (
  input  wire logic                              clk,
  input  wire sfa_pkg::dp_cmd_t                  cmd,
  input  wire logic signed [sfa_pkg::SMP_W-1:0]  sample,
  input  wire logic [$clog2(NFFT)-1:0]           ring_waddr,
  input  wire logic [$clog2(NFFT)-1:0]           ring_raddr,
  input  wire logic [$clog2(NFFT)-1:0]           win_idx,
  input  wire logic [$clog2(NFFT)-1:0]           ws_waddr,
  input  wire logic [$clog2(NFFT)-1:0]           ws_raddr,
  input  wire logic [$clog2(NFFT)-1:0]           tw_idx,
  input  wire logic [4:0]                        step,
  output logic      [sfa_pkg::MAG_W-1:0]         magnitude,
  output logic signed [sfa_pkg::PH_W-1:0]        phase
);
  import sfa_pkg::*;

  // constant tables: cosine, sine and hann weight per index
  logic signed [17:0] cos_tab [NFFT];
  logic signed [17:0] sin_tab [NFFT];
  logic        [16:0] win_tab [NFFT];

  for (genvar i = 0; i < NFFT; i++) begin : g_tab
    localparam int ANG = (i * 65536) / NFFT;
    localparam logic signed [17:0] COS_V = cordic_cs(ANG, 1'b0);
    localparam logic signed [17:0] SIN_V = cordic_cs(ANG, 1'b1);
    assign cos_tab[i] = COS_V;
    assign sin_tab[i] = SIN_V;
    assign win_tab[i] = hann_from_cos(COS_V);
  end

  // sample ring
  logic signed [SMP_W-1:0] ring_rdata;

  sfa_ram #(.WIDTH(SMP_W), .DEPTH(NFFT)) u_ring (
    .clk   (clk),
    .we    (cmd.ring_wr),
    .waddr (ring_waddr),
    .wdata (sample),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  // workspace, real part in the upper half
  logic [2*WS_W-1:0] ws_rdata;
  logic [2*WS_W-1:0] ws_wdata;
  logic              ws_we;

  sfa_ram #(.WIDTH(2*WS_W), .DEPTH(NFFT)) u_ws (
    .clk   (clk),
    .we    (ws_we),
    .waddr (ws_waddr),
    .wdata (ws_wdata),
    .raddr (ws_raddr),
    .rdata (ws_rdata)
  );

  // windowed sample, rounded half up
  logic signed [33:0] win_prod;
  logic signed [33:0] win_rnd;

  assign win_prod = 34'(ring_rdata) * 34'($signed({1'b0, win_tab[win_idx]}));
  assign win_rnd  = (win_prod + 34'sd16384) >>> 15;

  // butterfly twiddle product
  logic signed [WS_W-1:0] br;
  logic signed [WS_W-1:0] bi;
  logic signed [17:0]     tw_c;
  logic signed [17:0]     tw_s;
  logic signed [42:0]     pr;
  logic signed [42:0]     pi_;
  logic signed [WS_W-1:0] ar_r;
  logic signed [WS_W-1:0] ai_r;
  logic signed [27:0]     tr_r;
  logic signed [27:0]     ti_r;

  assign br   = ws_rdata[2*WS_W-1:WS_W];
  assign bi   = ws_rdata[WS_W-1:0];
  assign tw_c = cos_tab[tw_idx];
  assign tw_s = sin_tab[tw_idx];
  assign pr   = 43'(br * tw_c) + 43'(bi * tw_s);
  assign pi_  = 43'(bi * tw_c) - 43'(br * tw_s);

  always_ff @(posedge clk) begin
    if (cmd.bf_hold_a) begin
      ar_r <= br;
      ai_r <= bi;
    end
    if (cmd.bf_mul) begin
      tr_r <= 28'((pr + 43'sd16384) >>> 15);
      ti_r <= 28'((pi_ + 43'sd16384) >>> 15);
    end
  end

  // butterfly sums and differences
  logic signed [28:0] sum_r;
  logic signed [28:0] sum_i;
  logic signed [28:0] dif_r;
  logic signed [28:0] dif_i;

  assign sum_r = 29'(ar_r) + 29'(tr_r);
  assign sum_i = 29'(ai_r) + 29'(ti_r);
  assign dif_r = 29'(ar_r) - 29'(tr_r);
  assign dif_i = 29'(ai_r) - 29'(ti_r);

  // workspace write select
  assign ws_we = cmd.win_wr | cmd.bf_wr_a | cmd.bf_wr_b;

  always_comb begin
    if (cmd.win_wr) begin
      ws_wdata = {WS_W'(win_rnd), {WS_W{1'b0}}};
    end else if (cmd.bf_wr_a) begin
      ws_wdata = {sat_ws(sum_r), sat_ws(sum_i)};
    end else begin
      ws_wdata = {sat_ws(dif_r), sat_ws(dif_i)};
    end
  end

  // bin operands
  logic signed [WS_W-1:0] re_r;
  logic signed [WS_W-1:0] im_r;
  logic                   zero_r;

  // integer square root, one result bit per step
  logic [47:0] rem_r;
  logic [47:0] root_r;
  logic [47:0] bit_r;
  logic [48:0] trial;

  assign trial = {1'b0, root_r} + {1'b0, bit_r};

  // vectoring cordic for the phase
  logic signed [35:0] x_r;
  logic signed [35:0] y_r;
  logic signed [17:0] z_r;
  logic signed [35:0] x0;
  logic signed [35:0] y0;
  logic signed [35:0] xs;
  logic signed [35:0] ys;
  logic signed [17:0] at;

  assign x0 = 36'(re_r) <<< 8;
  assign y0 = 36'(im_r) <<< 8;
  assign xs = x_r >>> step[3:0];
  assign ys = y_r >>> step[3:0];
  assign at = $signed({3'b000, ATAN_TURNS[step[3:0]]});

  always_ff @(posedge clk) begin
    if (cmd.bin_load) begin
      re_r <= br;
      im_r <= bi;
    end
    if (cmd.bin_init) begin
      rem_r  <= 48'(re_r * re_r) + 48'(im_r * im_r);
      root_r <= '0;
      bit_r  <= 48'(1) << 46;
      zero_r <= (re_r == '0) && (im_r == '0);
      if (re_r < 0) begin
        z_r <= (im_r >= 0) ? 18'sd32768 : -18'sd32768;
        x_r <= -x0;
        y_r <= -y0;
      end else begin
        z_r <= '0;
        x_r <= x0;
        y_r <= y0;
      end
    end
    if (cmd.bin_step) begin
      if ({1'b0, rem_r} >= trial) begin
        rem_r  <= rem_r - 48'(trial);
        root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
      if (step < 5'(CORDIC_IT)) begin
        if (y_r > 0) begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + at;
        end else begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - at;
        end
      end
    end
  end

  // result fields
  assign magnitude = (root_r > 48'(MAG_MAX)) ? MAG_MAX : root_r[MAG_W-1:0];
  assign phase     = zero_r ? '0 : z_r[PH_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/sfa_ctrl.sv
// controller: frame scheduling, hop register, window, butterfly and bin sequencing
// depends on sfa_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none

`include "stft_frame_analyzer_unit_macros.svh"

module sfa_ctrl #(
  parameter int NFFT = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic                        in_start_of_signal,
  output logic                             in_ready,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [5:0]                       out_bin_index,
  output logic                             out_last_bin,
  input  wire logic                        cfg_we,
  input  wire logic [sfa_pkg::HOP_W-1:0]   cfg_wdata,
  output sfa_pkg::dp_cmd_t                 cmd,
  output logic [$clog2(NFFT)-1:0]          ring_waddr,
  output logic [$clog2(NFFT)-1:0]          ring_raddr,
  output logic [$clog2(NFFT)-1:0]          win_idx,
  output logic [$clog2(NFFT)-1:0]          ws_waddr,
  output logic [$clog2(NFFT)-1:0]          ws_raddr,
  output logic [$clog2(NFFT)-1:0]          tw_idx,
  output logic [4:0]                       step
);
  import sfa_pkg::*;

  localparam int AW  = $clog2(NFFT);
  localparam int QW  = AW - 1;
  localparam int SW  = $clog2(AW);
  localparam int SSW = $clog2(NFFT + 1);
  localparam int HCW = ($clog2(NFFT / 4 + 1) > HOP_W) ? $clog2(NFFT / 4 + 1) : HOP_W;

  ctl_state_t      state_r, state_nxt;
  logic [AW-1:0]   n_r, n_nxt;
  logic [SW-1:0]   stg_r, stg_nxt;
  logic [QW-1:0]   q_r, q_nxt;
  logic [AW-1:0]   f_r, f_nxt;
  logic [4:0]      cnt_r, cnt_nxt;
  logic [AW-1:0]   wptr_r, wptr_nxt;
  logic [SSW-1:0]  seen_r, seen_nxt;
  logic [HCW-1:0]  hc_r, hc_nxt;
  logic [HOP_W-1:0] hop_r;

  // hop register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hop_r <= HOP_RESET;
    end else if (cfg_we) begin
      hop_r <= cfg_wdata;
    end
  end

  // frame scheduling on an input transfer
  logic            in_xfer;
  logic [SSW-1:0]  seen_base;
  logic [HCW-1:0]  hc_base;
  logic [HCW-1:0]  hc_dec;
  logic [HCW-1:0]  hop_val;
  logic            emit;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign seen_base = in_start_of_signal ? '0 : seen_r;
  assign hc_base   = in_start_of_signal ? '0 : hc_r;
  assign hc_dec    = (hc_base != '0) ? hc_base - HCW'(1) : '0;
  assign hop_val   = (hop_r == '0) ? HCW'(NFFT / 4) : HCW'(hop_r);

  always_comb begin
    emit     = 1'b0;
    seen_nxt = seen_r;
    hc_nxt   = hc_r;
    wptr_nxt = wptr_r;
    if (in_xfer) begin
      wptr_nxt = wptr_r + AW'(1);
      if (seen_base < SSW'(NFFT)) begin
        seen_nxt = seen_base + SSW'(1);
        if (seen_base == SSW'(NFFT - 1)) begin
          emit   = 1'b1;
          hc_nxt = hop_val;
        end else begin
          hc_nxt = hc_base;
        end
      end else begin
        seen_nxt = seen_base;
        if (hc_dec == '0) begin
          emit   = 1'b1;
          hc_nxt = hop_val;
        end else begin
          hc_nxt = hc_dec;
        end
      end
    end
  end

  // butterfly addressing
  logic [AW-1:0] qa;
  logic [AW-1:0] mask;
  logic [AW-1:0] addr_a;
  logic [AW-1:0] addr_b;
  logic [AW-1:0] n_rev;

  assign qa     = AW'(q_r);
  assign mask   = (AW'(1) << stg_r) - AW'(1);
  assign addr_a = ((qa & ~mask) << 1) | (qa & mask);
  assign addr_b = addr_a | (AW'(1) << stg_r);
  assign tw_idx = (qa & mask) << (SW'(AW - 1) - stg_r);

  for (genvar b = 0; b < AW; b++) begin : g_rev
    assign n_rev[b] = n_r[AW-1-b];
  end

  // addresses to the datapath
  assign ring_waddr = wptr_r;
  assign ring_raddr = wptr_r + n_r;
  assign win_idx    = n_r;
  assign step       = cnt_r;
  assign ws_raddr   = (state_r == S_BF_RA) ? addr_a :
                      (state_r == S_BF_RB) ? addr_b : f_r;
  assign ws_waddr   = (state_r == S_WIN_WR) ? n_rev :
                      (state_r == S_BF_WA) ? addr_a : addr_b;

  // result handshake
  assign out_valid     = (state_r == S_BIN_OUT);
  assign out_bin_index = 6'(f_r);
  assign out_last_bin  = (f_r == AW'(NFFT / 2));

  // state and counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      n_r     <= '0;
      stg_r   <= '0;
      q_r     <= '0;
      f_r     <= '0;
      cnt_r   <= '0;
      wptr_r  <= '0;
      seen_r  <= '0;
      hc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      n_r     <= n_nxt;
      stg_r   <= stg_nxt;
      q_r     <= q_nxt;
      f_r     <= f_nxt;
      cnt_r   <= cnt_nxt;
      wptr_r  <= wptr_nxt;
      seen_r  <= seen_nxt;
      hc_r    <= hc_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    stg_nxt   = stg_r;
    q_nxt     = q_r;
    f_nxt     = f_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.ring_wr = in_xfer;
        if (emit) begin
          n_nxt     = '0;
          state_nxt = S_WIN_RD;
        end
      end
      S_WIN_RD: begin
        state_nxt = S_WIN_WR;
      end
      S_WIN_WR: begin
        cmd.win_wr = 1'b1;
        if (n_r == AW'(NFFT - 1)) begin
          stg_nxt   = '0;
          q_nxt     = '0;
          state_nxt = S_BF_RA;
        end else begin
          n_nxt     = n_r + AW'(1);
          state_nxt = S_WIN_RD;
        end
      end
      S_BF_RA: begin
        state_nxt = S_BF_RB;
      end
      S_BF_RB: begin
        cmd.bf_hold_a = 1'b1;
        state_nxt     = S_BF_MUL;
      end
      S_BF_MUL: begin
        cmd.bf_mul = 1'b1;
        state_nxt  = S_BF_WA;
      end
      S_BF_WA: begin
        cmd.bf_wr_a = 1'b1;
        state_nxt   = S_BF_WB;
      end
      S_BF_WB: begin
        cmd.bf_wr_b = 1'b1;
        q_nxt       = q_r + QW'(1);
        state_nxt   = S_BF_RA;
        if (q_r == '1) begin
          if (stg_r == SW'(AW - 1)) begin
            f_nxt     = '0;
            state_nxt = S_BIN_RD;
          end else begin
            stg_nxt = stg_r + SW'(1);
          end
        end
      end
      S_BIN_RD: begin
        state_nxt = S_BIN_WAIT;
      end
      S_BIN_WAIT: begin
        cmd.bin_load = 1'b1;
        state_nxt    = S_BIN_INIT;
      end
      S_BIN_INIT: begin
        cmd.bin_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_BIN_CALC;
      end
      S_BIN_CALC: begin
        cmd.bin_step = 1'b1;
        cnt_nxt      = cnt_r + 5'd1;
        if (cnt_r == 5'(CALC_STEPS - 1)) begin
          state_nxt = S_BIN_OUT;
        end
      end
      S_BIN_OUT: begin
        if (out_ready) begin
          if (out_last_bin) begin
            state_nxt = S_IDLE;
          end else begin
            f_nxt     = f_r + AW'(1);
            state_nxt = S_BIN_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // checks
  `SFA_ASSERT_NEXT(a_bin_held, out_valid && !out_ready, out_valid && $stable(f_r))
  `SFA_ASSERT_NOW(a_seen_bound, 1'b1, seen_r <= SSW'(NFFT))
  `SFA_ASSERT_NEXT(a_frame_end, out_valid && out_ready && out_last_bin, state_r == S_IDLE)
  `SFA_ASSERT_NOW(a_no_bin_idle, state_r == S_IDLE, !out_valid && f_r <= AW'(NFFT / 2))

endmodule

`default_nettype wire

FILE: rtl/stft_frame_analyzer_unit.sv
// top level of the streaming stft frame analyzer with periodic hann window
// depends on sfa_pkg, sfa_ctrl, sfa_datapath and sfa_ram
`timescale 1ns / 1ps
`default_nettype none

// Takes one padded sample per transfer and, after the first NFFT samples of a
// signal and then every hop_length samples, emits NFFT/2+1 bins of the
// windowed forward FFT, each with magnitude and phase. A sample that starts no
// frame leaves in_ready high. A sample that starts a frame holds the input
// through windowing, the butterflies on the workspace memory with its one
// read and one write port, and the iterative square root and phase rotation
// of every bin plus any wait on out_ready. The workspace memory and the one
// shared butterfly and bin units set this pace. hop_length of 0 means
// NFFT/4.

module stft_frame_analyzer_unit #(
  parameter int NFFT = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [15:0]            in_sample,
  input  wire logic                          in_start_of_signal,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [5:0]                         out_bin_index,
  output logic [sfa_pkg::MAG_W-1:0]          out_magnitude,
  output logic signed [sfa_pkg::PH_W-1:0]    out_phase,
  output logic                               out_last_bin,
  input  wire logic                          cfg_we,
  input  wire logic [sfa_pkg::HOP_W-1:0]     cfg_wdata
);
  import sfa_pkg::*;

  localparam int AW = $clog2(NFFT);

  dp_cmd_t       cmd;
  logic [AW-1:0] ring_waddr;
  logic [AW-1:0] ring_raddr;
  logic [AW-1:0] win_idx;
  logic [AW-1:0] ws_waddr;
  logic [AW-1:0] ws_raddr;
  logic [AW-1:0] tw_idx;
  logic [4:0]    step;

  // sequencing
  sfa_ctrl #(.NFFT(NFFT)) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_start_of_signal (in_start_of_signal),
    .in_ready           (in_ready),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_bin_index      (out_bin_index),
    .out_last_bin       (out_last_bin),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .cmd                (cmd),
    .ring_waddr         (ring_waddr),
    .ring_raddr         (ring_raddr),
    .win_idx            (win_idx),
    .ws_waddr           (ws_waddr),
    .ws_raddr           (ws_raddr),
    .tw_idx             (tw_idx),
    .step               (step)
  );

  // arithmetic and storage
  sfa_datapath #(.NFFT(NFFT)) u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .sample     (in_sample),
    .ring_waddr (ring_waddr),
    .ring_raddr (ring_raddr),
    .win_idx    (win_idx),
    .ws_waddr   (ws_waddr),
    .ws_raddr   (ws_raddr),
    .tw_idx     (tw_idx),
    .step       (step),
    .magnitude  (out_magnitude),
    .phase      (out_phase)
  );

endmodule

`default_nettype wire

FILE: tb/stft_bin_checker.sv
// checker for the stft frame analyzer: watches sample and bin transfers,
// predicts every bin of every frame and compares; depends on sfa_pkg
`timescale 1ns / 1ps

module stft_bin_checker #(
  parameter int NFFT = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic signed [15:0]             in_sample,
  input  logic                           in_start_of_signal,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [5:0]                     out_bin_index,
  input  logic [sfa_pkg::MAG_W-1:0]      out_magnitude,
  input  logic signed [sfa_pkg::PH_W-1:0] out_phase,
  input  logic                           out_last_bin,
  input  logic                           cfg_we,
  input  logic [sfa_pkg::HOP_W-1:0]      cfg_wdata,
  output int                             fail_count,
  output int                             bins_pending
);

  typedef struct packed {
    logic [5:0]  bin;
    logic [21:0] mag;
    logic [15:0] ph;
    logic        last;
  } bin_t;

  localparam longint GAIN_K = 652032874;
  localparam longint ARC_TURNS [16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                        41, 20, 10, 5, 3, 1, 1, 0};

  bin_t        expected_bins[$];
  longint      ring[NFFT];
  int unsigned seen_cnt, hop_left, wr_ptr;
  logic [6:0]  hop_reg;
  longint      wre[NFFT], wim[NFFT];

  // arithmetic shift and round-half-up shift
  function automatic longint shr(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint rnd_shr(longint v, int k);
    return (v + (longint'(1) << (k - 1))) >>> k;
  endfunction

  function automatic longint clip24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  // cosine and sine of a 16-bit turn angle
  task automatic trig(input longint ang, output longint c, output longint s);
    longint z, x, y, xs, ys;
    bit     flip;
    z = ang & 65535; x = GAIN_K; y = 0; flip = 0;
    if (z >= 32768) z -= 65536;
    if (z > 16384) begin
      z -= 32768; flip = 1;
    end else if (z < -16384) begin
      z += 32768; flip = 1;
    end
    for (int i = 0; i < 16; i++) begin
      xs = shr(x, i); ys = shr(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= ARC_TURNS[i];
      end else begin
        x += ys; y -= xs; z += ARC_TURNS[i];
      end
    end
    c = rnd_shr(x, 15); s = rnd_shr(y, 15);
    if (flip) begin
      c = -c; s = -s;
    end
  endtask

  function automatic logic [15:0] angle_of(longint re, longint im);
    longint x, y, z, xs, ys;
    x = re * 256; y = im * 256; z = 0;
    if (re == 0 && im == 0) return 16'd0;
    if (x < 0) begin
      z = (y >= 0) ? 32768 : -32768;
      x = -x; y = -y;
    end
    for (int i = 0; i < 16; i++) begin
      xs = shr(x, i); ys = shr(y, i);
      if (y > 0) begin
        x += ys; y -= xs; z += ARC_TURNS[i];
      end else begin
        x -= ys; y += xs; z -= ARC_TURNS[i];
      end
    end
    return z[15:0];
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0; b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b; r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return longint'(r);
  endfunction

  // window, fft and bin conversion of the current ring contents
  task automatic push_frame_bins();
    longint c, s, w, tr, ti, ar, ai, re, im, mag;
    int     lg, r, t, half;
    bin_t   e;
    lg = $clog2(NFFT);
    for (int n = 0; n < NFFT; n++) begin
      trig((n * 65536) / NFFT, c, s);
      if (c > 32768) c = 32768;
      if (c < -32768) c = -32768;
      w = (32768 - c) >>> 1;
      r = 0; t = n;
      for (int b = 0; b < lg; b++) begin
        r = (r << 1) | (t & 1); t >>= 1;
      end
      wre[r] = rnd_shr(ring[(wr_ptr + n) % NFFT] * w, 15);
      wim[r] = 0;
    end
    for (int m = 2; m <= NFFT; m <<= 1) begin
      half = m >> 1;
      for (int k = 0; k < half; k++) begin
        trig(k * (65536 / m), c, s);
        for (int j = k; j < NFFT; j += m) begin
          tr = rnd_shr(wre[j + half] * c + wim[j + half] * s, 15);
          ti = rnd_shr(wim[j + half] * c - wre[j + half] * s, 15);
          ar = wre[j]; ai = wim[j];
          wre[j] = clip24(ar + tr); wim[j] = clip24(ai + ti);
          wre[j + half] = clip24(ar - tr); wim[j + half] = clip24(ai - ti);
        end
      end
    end
    for (int f = 0; f <= NFFT / 2; f++) begin
      re = wre[f]; im = wim[f];
      mag = int_sqrt(re * re + im * im);
      if (mag > 4194303) mag = 4194303;
      e.bin = f[5:0]; e.mag = mag[21:0]; e.ph = angle_of(re, im);
      e.last = (f == NFFT / 2);
      expected_bins.push_back(e);
    end
  endtask

  function automatic int unsigned hop_now();
    return (hop_reg == 0) ? NFFT / 4 : hop_reg;
  endfunction

  // sample transfer: update the ring and frame counters
  task automatic take_sample(logic signed [15:0] smp, logic sos);
    if (sos) begin
      seen_cnt = 0; hop_left = 0;
    end
    ring[wr_ptr] = smp;
    wr_ptr = (wr_ptr + 1) % NFFT;
    if (seen_cnt < NFFT) begin
      seen_cnt++;
      if (seen_cnt == NFFT) begin
        hop_left = hop_now(); push_frame_bins();
      end
    end else begin
      if (hop_left > 0) hop_left--;
      if (hop_left == 0) begin
        hop_left = hop_now(); push_frame_bins();
      end
    end
  endtask

  assign bins_pending = expected_bins.size();

  always @(posedge clk) begin
    bin_t e;
    if (!rst_n) begin
      expected_bins.delete();
      foreach (ring[i]) ring[i] = 0;
      seen_cnt = 0; hop_left = 0; wr_ptr = 0;
      hop_reg = sfa_pkg::HOP_RESET;
      fail_count <= 0;
    end else begin
      // bin transfer compare
      if (out_valid && out_ready) begin
        if (expected_bins.size() == 0) begin
          $display("%0t: unexpected bin transfer, bin %0d", $time, out_bin_index);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_bins.pop_front();
          if (e.bin !== out_bin_index || e.mag !== out_magnitude ||
              e.ph !== out_phase || e.last !== out_last_bin) begin
            $display("%0t: bin mismatch expected bin %0d mag %0d ph %0d last %0b",
                     $time, e.bin, e.mag, $signed(e.ph), e.last);
            $display("%0t:                actual bin %0d mag %0d ph %0d last %0b",
                     $time, out_bin_index, out_magnitude, out_phase, out_last_bin);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) take_sample(in_sample, in_start_of_signal);
      if (cfg_we) hop_reg = cfg_wdata;
    end
  end

endmodule

FILE: tb/testbench.sv
// stimulus and verdict for stft_frame_analyzer_unit
// depends on sfa_pkg, the rtl and tb/stft_bin_checker.sv
`timescale 1ns / 1ps

module testbench;

  localparam int NFFT = 64;
  localparam int STALL_LIMIT = 20000;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_ready;
  logic signed [15:0] in_sample = 0;
  logic in_start_of_signal = 0;
  logic out_valid, out_ready = 0;
  logic [5:0] out_bin_index;
  logic [sfa_pkg::MAG_W-1:0] out_magnitude;
  logic signed [sfa_pkg::PH_W-1:0] out_phase;
  logic out_last_bin;
  logic cfg_we = 0;
  logic [sfa_pkg::HOP_W-1:0] cfg_wdata = 0;
  int   fail_count, bins_pending;
  int   idle_cycles = 0;
  bit   calm = 0;

  always #5 clk = ~clk;

  stft_frame_analyzer_unit #(.NFFT(NFFT)) u_top (.*);

  stft_bin_checker #(.NFFT(NFFT)) u_chk (.*);

  // receiver side stalls in bursts
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 11);
        out_ready <= 0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1;
    end
  end

  // watchdog over cycles with no transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // one sample transfer, optional sender gap first
  task automatic send_sample(input logic [15:0] smp, input logic sos);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1; in_sample <= smp; in_start_of_signal <= sos;
    do @(posedge clk); while (!in_ready);
  endtask

  // hop write once every expected bin is out and the block is quiet
  task automatic set_hop(input logic [6:0] hop);
    @(posedge clk);
    while (bins_pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    cfg_we <= 1; cfg_wdata <= hop;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic send_signal(input int len, input int kind);
    logic [15:0] v;
    for (int i = 0; i < len; i++) begin
      case (kind)
        0: v = $urandom;
        1: v = (i % 2) ? 16'h8000 : 16'h7fff;
        2: v = 16'h7fff;
        3: v = 16'h0000;
        default: v = $urandom_range(0, 1) ? 16'h8000 : $urandom;
      endcase
      send_sample(v, i == 0);
    end
    in_valid <= 0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1;
    // directed: zero signal at reset hop, alternating, half-minimum random and full-scale signals
    send_signal(NFFT + 2, 3);
    set_hop(7'd0);
    send_signal(NFFT + 17, 1);
    set_hop(7'd1);
    send_signal(NFFT + 3, 4);
    set_hop(7'd127);
    send_signal(NFFT + 2, 2);
    // random: a random hop with no idling, then a short signal and a longer one
    calm = 1;
    set_hop(7'($urandom_range(2, 20)));
    send_signal(NFFT / 2, 0);
    send_signal(NFFT + 6, 0);
    // drain
    @(posedge clk);
    while (bins_pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
